### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPLIES(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

### hw/rtl/rdi_pkg.sv
// Types, widths and register codes for the ray/disk intersection pipeline.
package rdi_pkg;

	localparam int unsigned COORD_W    = 32;
	localparam int unsigned NORM_W     = 18;
	localparam int unsigned RAD_W      = 63;
	localparam int unsigned MIN_W      = 16;
	localparam int unsigned TLIM_W     = 31;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 63;
	// signed dot product widths: numerator (33b x 18b) x3, denominator (32b x 18b) x3
	localparam int unsigned NUM_W      = 53;
	localparam int unsigned DEN_W      = 52;
	// quotient bits produced by the divider; covers the overflow limit 2^31
	localparam int unsigned QUOT_W     = 33;
	localparam int unsigned FRAC_BITS_DEF = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X       = 4'd0,
		REG_CENTER_Y       = 4'd1,
		REG_CENTER_Z       = 4'd2,
		REG_NORMAL_X       = 4'd3,
		REG_NORMAL_Y       = 4'd4,
		REG_NORMAL_Z       = 4'd5,
		REG_RADIUS_SQUARED = 4'd6,
		REG_MIN_DISTANCE   = 4'd7
	} cfg_reg_t;

	typedef logic [2:0][COORD_W-1:0] vec3_t;
	typedef logic [2:0][NORM_W-1:0]  norm3_t;

	typedef struct packed {
		vec3_t              origin;
		vec3_t              dir;
		logic [TLIM_W-1:0]  t_limit;
		logic               shadow;
	} ray_t;

	typedef struct packed {
		logic             neg;
		logic             zero;
		logic [NUM_W-1:0] num_mag;
		logic [DEN_W-1:0] den_mag;
	} div_op_t;

endpackage

### hw/rtl/rdi_front.sv
// Front pipeline: center-origin differences, dot products with the normal, magnitudes.
module rdi_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  rdi_pkg::ray_t  ray,
	input  rdi_pkg::vec3_t center,
	input  rdi_pkg::norm3_t normal,
	output logic           valid,
	output rdi_pkg::ray_t  ray_out,
	output rdi_pkg::div_op_t op
);

	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	rdi_pkg::ray_t       ray_s1, ray_s2, ray_s3, ray_s4;
	logic signed [32:0]  diff_s1 [3];
	logic signed [50:0]  pn_s2 [3];
	logic signed [49:0]  dn_s2 [3];
	logic signed [rdi_pkg::NUM_W-1:0] num_s3;
	logic signed [rdi_pkg::DEN_W-1:0] den_s3;
	rdi_pkg::div_op_t    op_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray_s1 <= ray;
			for (int i = 0; i < 3; i++) begin
				diff_s1[i] <= 33'($signed(center[i])) - 33'($signed(ray.origin[i]));
			end
			ray_s2 <= ray_s1;
			for (int i = 0; i < 3; i++) begin
				pn_s2[i] <= 51'(diff_s1[i] * 51'($signed(normal[i])));
				dn_s2[i] <= 50'(50'($signed(ray_s1.dir[i])) * 50'($signed(normal[i])));
			end
			ray_s3 <= ray_s2;
			num_s3 <= rdi_pkg::NUM_W'(pn_s2[0]) + rdi_pkg::NUM_W'(pn_s2[1])
				+ rdi_pkg::NUM_W'(pn_s2[2]);
			den_s3 <= rdi_pkg::DEN_W'(dn_s2[0]) + rdi_pkg::DEN_W'(dn_s2[1])
				+ rdi_pkg::DEN_W'(dn_s2[2]);
			ray_s4 <= ray_s3;
			op_s4.neg     <= num_s3[rdi_pkg::NUM_W-1] ^ den_s3[rdi_pkg::DEN_W-1];
			op_s4.zero    <= (den_s3 == '0);
			op_s4.num_mag <= num_s3[rdi_pkg::NUM_W-1] ? rdi_pkg::NUM_W'(-num_s3)
				: rdi_pkg::NUM_W'(num_s3);
			op_s4.den_mag <= den_s3[rdi_pkg::DEN_W-1] ? rdi_pkg::DEN_W'(-den_s3)
				: rdi_pkg::DEN_W'(den_s3);
		end
	end

	assign valid   = vld_s4;
	assign ray_out = ray_s4;
	assign op      = op_s4;

endmodule

### hw/rtl/rdi_divider.sv
// Pipelined restoring divider: one quotient bit per stage of (num << F) / den.
module rdi_divider #(
	parameter int unsigned FRAC_BITS = rdi_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  rdi_pkg::div_op_t op,
	input  rdi_pkg::ray_t    ray,
	output logic             valid,
	output logic [rdi_pkg::QUOT_W-1:0] quot,
	output logic             neg,
	output logic             fail,
	output rdi_pkg::ray_t    ray_out
);

	localparam int unsigned QW    = rdi_pkg::QUOT_W;
	localparam int unsigned REM_W = rdi_pkg::DEN_W;
	localparam int unsigned N_W   = rdi_pkg::NUM_W + FRAC_BITS;

	logic [N_W-1:0]          dividend;
	logic [N_W-QW-1:0]       top;

	logic                    vld_s  [0:QW];
	logic [REM_W-1:0]        rem_s  [0:QW];
	logic [QW-1:0]           low_s  [0:QW];
	logic [QW-1:0]           quo_s  [0:QW];
	logic [REM_W-1:0]        den_s  [0:QW];
	logic                    neg_s  [0:QW];
	logic                    fail_s [0:QW];
	rdi_pkg::ray_t           ray_s  [0:QW];

	assign dividend = {op.num_mag, FRAC_BITS'(0)};
	assign top      = dividend[N_W-1:QW];

	// entry stage: a zero divisor, or a quotient of 2^QW or more as overflow, is flagged here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= REM_W'(top);
			low_s[0]  <= dividend[QW-1:0];
			quo_s[0]  <= '0;
			den_s[0]  <= op.den_mag;
			neg_s[0]  <= op.neg;
			fail_s[0] <= op.zero || ({{REM_W{1'b0}}, top} >= {{(N_W-QW){1'b0}}, op.den_mag});
			ray_s[0]  <= ray;
		end
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [REM_W:0] trial;
		logic           ge;

		assign trial = {rem_s[k-1], low_s[k-1][QW-1]};
		assign ge    = (trial >= {1'b0, den_s[k-1]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? REM_W'(trial - {1'b0, den_s[k-1]}) : REM_W'(trial);
				low_s[k]  <= {low_s[k-1][QW-2:0], 1'b0};
				quo_s[k]  <= {quo_s[k-1][QW-2:0], ge};
				den_s[k]  <= den_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				fail_s[k] <= fail_s[k-1];
				ray_s[k]  <= ray_s[k-1];
			end
		end
	end

	assign valid   = vld_s[QW];
	assign quot    = quo_s[QW];
	assign neg     = neg_s[QW];
	assign fail    = fail_s[QW];
	assign ray_out = ray_s[QW];

endmodule

### hw/rtl/rdi_back.sv
// Back pipeline: distance checks, hit point, squared radius test and result register.
module rdi_back #(
	parameter int unsigned FRAC_BITS = rdi_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [rdi_pkg::QUOT_W-1:0] quot,
	input  logic           neg,
	input  logic           fail,
	input  rdi_pkg::ray_t  ray,
	input  rdi_pkg::vec3_t center,
	input  logic [rdi_pkg::RAD_W-1:0] radius_squared,
	input  logic [rdi_pkg::MIN_W-1:0] min_distance,
	output logic           valid,
	output logic           is_hit,
	output logic signed [31:0] hit_distance,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);

	localparam int unsigned QW    = rdi_pkg::QUOT_W;
	localparam int unsigned TERM_W = 64 - FRAC_BITS;
	localparam int unsigned P_W    = TERM_W + 1;
	localparam int unsigned D_W    = P_W + 1;

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic                    hit_s1, hit_s2, hit_s3, hit_s4, hit_s5, hit_s6;
	logic signed [31:0]      t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;
	rdi_pkg::ray_t           ray_s1, ray_s2;
	logic signed [63:0]      prod_s2 [3];
	logic signed [P_W-1:0]   p_s3 [3];
	logic [31:0]             a_s4 [3];
	logic [31:0]             p_s4 [3], p_s5 [3], p_s6 [3];
	logic [63:0]             sq_s5 [3];
	logic [65:0]             sum_s6;

	logic                    hit_s7;
	logic signed [31:0]      t_s7, px_s7, py_s7, pz_s7;

	logic                    over;
	logic signed [31:0]      t_c;
	logic                    hit_c;
	logic                    hit4_c;
	logic signed [D_W-1:0]   diff_c [3];
	logic [D_W-1:0]          amag_c [3];

	// quotient limit: 2^31 for a negative result, 2^31 - 1 otherwise
	always_comb begin
		over  = neg ? (quot > QW'(33'h0_8000_0000)) : (quot > QW'(33'h0_7FFF_FFFF));
		t_c   = neg ? -$signed(quot[31:0]) : $signed(quot[31:0]);
		hit_c = !fail && !over
			&& !(t_c < $signed(32'(min_distance)))
			&& !(!ray.shadow && (t_c > $signed(32'(ray.t_limit))));
	end

	always_comb begin
		hit4_c = hit_s3;
		for (int i = 0; i < 3; i++) begin
			diff_c[i] = D_W'($signed(center[i])) - D_W'(p_s3[i]);
			amag_c[i] = diff_c[i][D_W-1] ? D_W'(-diff_c[i]) : D_W'(diff_c[i]);
			// drop far points and points outside the signed 32-bit range
			if (amag_c[i][D_W-1:32] != '0) begin
				hit4_c = 1'b0;
			end
			if ((p_s3[i][P_W-1:31] != '0) && (p_s3[i][P_W-1:31] != '1)) begin
				hit4_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1   <= t_c;
			hit_s1 <= hit_c;
			ray_s1 <= ray;

			t_s2   <= t_s1;
			hit_s2 <= hit_s1;
			ray_s2 <= ray_s1;
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= 64'($signed(ray_s1.dir[i])) * 64'(t_s1);
			end

			// truncate dir * t toward zero, then add the origin
			t_s3   <= t_s2;
			hit_s3 <= hit_s2;
			for (int i = 0; i < 3; i++) begin
				p_s3[i] <= P_W'($signed(ray_s2.origin[i]))
					+ P_W'($signed(prod_s2[i][63:FRAC_BITS]))
					+ P_W'(prod_s2[i][63] && (prod_s2[i][FRAC_BITS-1:0] != '0));
			end

			t_s4   <= t_s3;
			hit_s4 <= hit4_c;
			for (int i = 0; i < 3; i++) begin
				a_s4[i] <= amag_c[i][31:0];
				p_s4[i] <= p_s3[i][31:0];
			end

			t_s5   <= t_s4;
			hit_s5 <= hit_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= 64'(a_s4[i]) * 64'(a_s4[i]);
				p_s5[i]  <= p_s4[i];
			end

			t_s6   <= t_s5;
			hit_s6 <= hit_s5;
			sum_s6 <= 66'(sq_s5[0]) + 66'(sq_s5[1]) + 66'(sq_s5[2]);
			for (int i = 0; i < 3; i++) begin
				p_s6[i] <= p_s5[i];
			end

			// result register: zero all fields on a miss
			hit_s7 <= hit_s6 && (sum_s6 < 66'(radius_squared));
			if (hit_s6 && (sum_s6 < 66'(radius_squared))) begin
				t_s7  <= t_s6;
				px_s7 <= $signed(p_s6[0]);
				py_s7 <= $signed(p_s6[1]);
				pz_s7 <= $signed(p_s6[2]);
			end else begin
				t_s7  <= '0;
				px_s7 <= '0;
				py_s7 <= '0;
				pz_s7 <= '0;
			end
		end
	end

	assign valid        = vld_s7;
	assign is_hit       = hit_s7;
	assign hit_distance = t_s7;
	assign point_x      = px_s7;
	assign point_y      = py_s7;
	assign point_z      = pz_s7;

endmodule

### hw/rtl/ray_disk_intersection.sv
// Ray/disk intersection in fixed point. One ray is accepted every clock while the output
// is not stalled; each ray yields exactly one result after its transfer, through
// 4 front stages for the dot products, 34 divider stages (an overflow check followed by
// 33 stages producing one quotient bit each) and 7 back stages for the hit point and radius
// test. A stall on a valid output freezes the whole pipeline and is mirrored on in_stall.
// Coordinates are signed Q.F with F = FRAC_BITS, the squared radius carries 2F fraction
// bits; on a miss all result fields are 0.
// Disk registers may only be written while no ray is in flight.
`include "assert_macros.svh"

module ray_disk_intersection #(
	parameter int unsigned FRAC_BITS = rdi_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_write,
	input  logic [rdi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rdi_pkg::CFG_DATA_W-1:0] cfg_data,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] dir_x,
	input  logic signed [31:0] dir_y,
	input  logic signed [31:0] dir_z,
	input  logic [30:0] t_limit,
	input  logic        shadow_query,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_hit,
	output logic signed [31:0] hit_distance,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);

	rdi_pkg::vec3_t                   center_q;
	rdi_pkg::norm3_t                  normal_q;
	logic [rdi_pkg::RAD_W-1:0]        radius_squared_q;
	logic [rdi_pkg::MIN_W-1:0]        min_distance_q;

	logic                             en;
	rdi_pkg::ray_t                    ray_in, ray_f, ray_d;
	rdi_pkg::div_op_t                 op_f;
	logic                             vld_f, vld_d;
	logic [rdi_pkg::QUOT_W-1:0]       quot_d;
	logic                             neg_d, fail_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q         <= '0;
			normal_q         <= {18'h10000, 18'h0, 18'h0};
			radius_squared_q <= 63'h1_0000_0000;
			min_distance_q   <= 16'd66;
		end else if (cfg_write) begin
			case (rdi_pkg::cfg_reg_t'(cfg_index))
				rdi_pkg::REG_CENTER_X:       center_q[0] <= cfg_data[31:0];
				rdi_pkg::REG_CENTER_Y:       center_q[1] <= cfg_data[31:0];
				rdi_pkg::REG_CENTER_Z:       center_q[2] <= cfg_data[31:0];
				rdi_pkg::REG_NORMAL_X:       normal_q[0] <= cfg_data[17:0];
				rdi_pkg::REG_NORMAL_Y:       normal_q[1] <= cfg_data[17:0];
				rdi_pkg::REG_NORMAL_Z:       normal_q[2] <= cfg_data[17:0];
				rdi_pkg::REG_RADIUS_SQUARED: radius_squared_q <= cfg_data;
				rdi_pkg::REG_MIN_DISTANCE:   min_distance_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// hold every stage while a finished result waits
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	assign ray_in.origin  = {origin_z, origin_y, origin_x};
	assign ray_in.dir     = {dir_z, dir_y, dir_x};
	assign ray_in.t_limit = t_limit;
	assign ray_in.shadow  = shadow_query;

	rdi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.ray      (ray_in),
		.center   (center_q),
		.normal   (normal_q),
		.valid    (vld_f),
		.ray_out  (ray_f),
		.op       (op_f)
	);

	rdi_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_f),
		.op       (op_f),
		.ray      (ray_f),
		.valid    (vld_d),
		.quot     (quot_d),
		.neg      (neg_d),
		.fail     (fail_d),
		.ray_out  (ray_d)
	);

	rdi_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.in_valid       (vld_d),
		.quot           (quot_d),
		.neg            (neg_d),
		.fail           (fail_d),
		.ray            (ray_d),
		.center         (center_q),
		.radius_squared (radius_squared_q),
		.min_distance   (min_distance_q),
		.valid          (out_valid),
		.is_hit         (is_hit),
		.hit_distance   (hit_distance),
		.point_x        (point_x),
		.point_y        (point_y),
		.point_z        (point_z)
	);

	`ASSERT_IMPLIES(a_miss_zero, out_valid && !is_hit, (hit_distance == '0) && (point_x == '0) && (point_y == '0) && (point_z == '0), "miss result carries nonzero fields")
	`ASSERT_IMPLIES(a_hit_min, out_valid && is_hit, hit_distance >= $signed(32'(min_distance_q)), "hit closer than minimum distance")
	`ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(is_hit), "stalled result lost")

endmodule

### tb/testbench.sv
// Self-checking testbench for the ray/disk intersection pipeline.
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned WATCHDOG_LIMIT = 5000;
	localparam int unsigned DRAIN_CYCLES   = 60;

	typedef struct {
		logic signed [31:0] org [3];
		logic signed [31:0] dir [3];
		logic [30:0]        tlim;
		logic               shadow;
	} ray_item_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] t;
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
	} disk_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write;
	logic [rdi_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [rdi_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_stall;
	logic signed [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
	logic [30:0] t_limit;
	logic shadow_query;
	logic out_valid, out_stall;
	logic is_hit;
	logic signed [31:0] hit_distance, point_x, point_y, point_z;

	// disk registers as the checker sees them
	logic signed [31:0] disk_cen [3];
	logic signed [17:0] disk_nrm [3];
	logic [62:0]        disk_rad2;
	logic [15:0]        disk_tmin;

	ray_item_t rays_pending [$];
	disk_res_t hits_expected [$];
	int unsigned errors = 0;
	int unsigned rays_sent = 0;
	int unsigned hits_seen = 0;
	int unsigned watchdog = 0;
	int unsigned in_gap = 0;
	int unsigned stall_gap = 0;
	logic quiet = 1'b0;
	logic in_took = 1'b0;

	ray_disk_intersection u_top (.*);

	always #2 clk = ~clk;

	function automatic disk_res_t disk_hit(ray_item_t r);
		longint c [3], nv [3], o [3], d [3], p [3];
		longint num, den, t, prod, diff;
		logic [127:0] nm, dm, q;
		logic [63:0] a, sq, d2, m;
		logic hit, neg;
		disk_res_t res;
		num = 0;
		den = 0;
		for (int i = 0; i < 3; i++) begin
			c[i] = disk_cen[i];
			nv[i] = disk_nrm[i];
			o[i] = r.org[i];
			d[i] = r.dir[i];
			num += (c[i] - o[i]) * nv[i];
			den += d[i] * nv[i];
		end
		hit = 1'b1;
		t = 0;
		if (den == 0) begin
			hit = 1'b0;
		end else begin
			nm = 128'(num < 0 ? -num : num);
			dm = 128'(den < 0 ? -den : den);
			neg = (num < 0) != (den < 0);
			if (nm / dm > 128'(1 << 15)) begin
				hit = 1'b0;
			end else begin
				q = (nm << 16) / dm;
				if (q > (neg ? 128'h8000_0000 : 128'h7fff_ffff))
					hit = 1'b0;
				else
					t = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
			end
		end
		if (hit && t < longint'(disk_tmin))
			hit = 1'b0;
		if (hit && !r.shadow && t > longint'(r.tlim))
			hit = 1'b0;
		if (hit) begin
			d2 = 0;
			for (int i = 0; i < 3; i++) begin
				prod = d[i] * t;
				m = (prod < 0) ? 64'(-prod) : 64'(prod);
				m = m >> 16;
				p[i] = o[i] + ((prod < 0) ? -longint'(m) : longint'(m));
				diff = c[i] - p[i];
				a = (diff < 0) ? 64'(-diff) : 64'(diff);
				if (a >= 64'h1_0000_0000) begin
					hit = 1'b0;
					break;
				end
				sq = a * a;
				d2 = (d2 + sq < d2) ? '1 : d2 + sq;
				if (p[i] < -64'sd2147483648 || p[i] > 64'sd2147483647)
					hit = 1'b0;
			end
			if (hit && !(d2 < {1'b0, disk_rad2}))
				hit = 1'b0;
		end
		res = '0;
		if (hit) begin
			res.hit = 1'b1;
			res.t = t[31:0];
			res.px = p[0][31:0];
			res.py = p[1][31:0];
			res.pz = p[2][31:0];
		end
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h want %h", what, got, want);
	endtask

	task automatic cfg_put(logic [rdi_pkg::CFG_IDX_W-1:0] idx,
			logic [rdi_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (rdi_pkg::cfg_reg_t'(idx))
			rdi_pkg::REG_CENTER_X: disk_cen[0] = val[31:0];
			rdi_pkg::REG_CENTER_Y: disk_cen[1] = val[31:0];
			rdi_pkg::REG_CENTER_Z: disk_cen[2] = val[31:0];
			rdi_pkg::REG_NORMAL_X: disk_nrm[0] = val[17:0];
			rdi_pkg::REG_NORMAL_Y: disk_nrm[1] = val[17:0];
			rdi_pkg::REG_NORMAL_Z: disk_nrm[2] = val[17:0];
			rdi_pkg::REG_RADIUS_SQUARED: disk_rad2 = val;
			rdi_pkg::REG_MIN_DISTANCE: disk_tmin = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz,
			logic [30:0] tl, logic sh);
		ray_item_t r;
		r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
		r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
		r.tlim = tl;
		r.shadow = sh;
		rays_pending.push_back(r);
	endtask

	// Aim at a point near the disk center, else random noise.
	task automatic add_random(int count);
		ray_item_t r;
		int sh;
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(0, 9) < 7) begin
				sh = $urandom_range(0, 8);
				for (int i = 0; i < 3; i++) begin
					r.org[i] = disk_cen[i] + int'($urandom_range(0, 2 << 20)) - (1 << 20);
					r.dir[i] = disk_cen[i] + int'($urandom_range(0, 1 << 18)) - (1 << 17)
						- r.org[i];
					r.dir[i] = (sh < 4) ? (r.dir[i] <<< sh) : (r.dir[i] >>> (sh - 4));
				end
				r.tlim = ($urandom_range(0, 3) == 0) ? 31'($urandom) :
					31'($urandom_range(1 << 14, 1 << 21));
			end else begin
				for (int i = 0; i < 3; i++) begin
					r.org[i] = $urandom;
					r.dir[i] = $urandom;
				end
				r.tlim = 31'($urandom);
			end
			r.shadow = $urandom_range(0, 1);
			rays_pending.push_back(r);
		end
	endtask

	task automatic random_disk();
		cfg_put(rdi_pkg::REG_CENTER_X, 63'(int'($urandom_range(0, 1 << 25)) - (1 << 24)));
		cfg_put(rdi_pkg::REG_CENTER_Y, 63'(int'($urandom_range(0, 1 << 25)) - (1 << 24)));
		cfg_put(rdi_pkg::REG_CENTER_Z, 63'(int'($urandom_range(0, 1 << 25)) - (1 << 24)));
		cfg_put(rdi_pkg::REG_NORMAL_X, 63'(int'($urandom_range(0, 131072)) - 65536));
		cfg_put(rdi_pkg::REG_NORMAL_Y, 63'(int'($urandom_range(0, 131072)) - 65536));
		cfg_put(rdi_pkg::REG_NORMAL_Z, 63'(int'($urandom_range(0, 131072)) - 65536));
		cfg_put(rdi_pkg::REG_RADIUS_SQUARED, 63'($urandom_range(0, 1 << 18)) ** 2);
		cfg_put(rdi_pkg::REG_MIN_DISTANCE, 63'($urandom_range(0, 65535)));
	endtask

	task automatic drain();
		while (rays_pending.size() != 0 || in_valid || hits_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Ray driver: advance only after a transfer or while idle.
	always @(negedge clk) begin
		ray_item_t r;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_took || !in_valid) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				in_gap <= $urandom_range(0, 16);
				in_valid <= 1'b0;
			end else if (rays_pending.size() > 0) begin
				r = rays_pending.pop_front();
				origin_x <= r.org[0]; origin_y <= r.org[1]; origin_z <= r.org[2];
				dir_x <= r.dir[0]; dir_y <= r.dir[1]; dir_z <= r.dir[2];
				t_limit <= r.tlim;
				shadow_query <= r.shadow;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_gap > 0) begin
			stall_gap <= stall_gap - 1;
			out_stall <= 1'b1;
		end else if (!quiet && arst_n && $urandom_range(0, 11) == 0) begin
			stall_gap <= $urandom_range(0, 16);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Predict on each ray transfer, check on each result transfer.
	always @(posedge clk) begin
		ray_item_t r;
		disk_res_t want;
		in_took = arst_n && in_valid && !in_stall;
		if (in_took) begin
			r.org[0] = origin_x; r.org[1] = origin_y; r.org[2] = origin_z;
			r.dir[0] = dir_x; r.dir[1] = dir_y; r.dir[2] = dir_z;
			r.tlim = t_limit;
			r.shadow = shadow_query;
			hits_expected.push_back(disk_hit(r));
			rays_sent++;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (hits_expected.size() == 0) begin
				report("unexpected result", 32'(is_hit), 32'h0);
			end else begin
				want = hits_expected.pop_front();
				if (want.hit) hits_seen++;
				if (is_hit !== want.hit) report("is_hit", 32'(is_hit), 32'(want.hit));
				if (hit_distance !== want.t) report("hit_distance", hit_distance, want.t);
				if (point_x !== want.px) report("point_x", point_x, want.px);
				if (point_y !== want.py) report("point_y", point_y, want.py);
				if (point_z !== want.pz) report("point_z", point_z, want.pz);
			end
		end
		if (in_took || (out_valid && !out_stall) || !arst_n) begin
			watchdog <= 0;
		end else begin
			watchdog <= watchdog + 1;
			if (watchdog >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", watchdog);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		origin_x = 0; origin_y = 0; origin_z = 0;
		dir_x = 0; dir_y = 0; dir_z = 0;
		t_limit = '0;
		shadow_query = 1'b0;
		disk_cen = '{0, 0, 0};
		disk_nrm = '{0, 0, 18'sd65536};
		disk_rad2 = 63'h1_0000_0000;
		disk_tmin = 16'd66;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset disk: unit disk in the z = 0 plane
		add_ray(0, 0, 2 << 16, 0, 0, -65536, 31'h7fff_ffff, 1'b0);
		add_ray(0, 0, 2 << 16, 0, 0, -65536, 31'h10000, 1'b0);
		add_ray(0, 0, 2 << 16, 0, 0, -65536, 31'h10000, 1'b1);
		add_ray(0, 0, 2 << 16, 0, 0, -65536, 31'h0, 1'b1);
		add_ray(0, 0, 1 << 16, 65536, 0, 0, 31'h7fff_ffff, 1'b1);
		add_ray(0, 0, 32'h7fff_ffff, 0, 0, -1, 31'h7fff_ffff, 1'b1);
		add_ray(0, 0, 32'h7fff_ffff, 0, 0, -32'sd2147483648, 31'h7fff_ffff, 1'b1);
		add_ray(2 << 16, 0, 1 << 16, 0, 0, -65536, 31'h7fff_ffff, 1'b0);
		add_ray(0, 0, 1, 0, 0, -65536, 31'h7fff_ffff, 1'b0);
		add_ray(0, 0, 66, 0, 0, -65536, 31'h7fff_ffff, 1'b0);
		add_ray(0, 0, 65, 0, 0, -65536, 31'h7fff_ffff, 1'b0);
		add_ray(32'h7fff_ffff, 0, 1 << 16, 65536, 0, -65536, 31'h7fff_ffff, 1'b1);
		add_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 1'b1);
		add_ray(-32'sd2147483648, -32'sd2147483648, -32'sd2147483648,
			-32'sd2147483648, -32'sd2147483648, -32'sd2147483648, 31'h0, 1'b0);
		add_ray(0, 0, -32'sd2147483648, 0, 0, 32'h7fff_ffff, 31'h7fff_ffff, 1'b0);
		add_ray(16384, -16384, -(3 << 16), 0, 0, 65536, 31'h30000, 1'b0);
		add_ray(65535, 0, 65536, 0, 0, -65536, 31'h7fff_ffff, 1'b0);
		add_ray(65536, 0, 65536, 0, 0, -65536, 31'h7fff_ffff, 1'b0);
		drain();

		// extreme disk: far corner center, normal components of +-1.0, widest radius
		cfg_put(rdi_pkg::REG_CENTER_X, 63'h7fff_ffff_8000_0000);
		cfg_put(rdi_pkg::REG_CENTER_Y, 63'h7fff_ffff);
		cfg_put(rdi_pkg::REG_CENTER_Z, 63'h0);
		cfg_put(rdi_pkg::REG_NORMAL_X, 63'h7fff_ffff_fffd_0000);
		cfg_put(rdi_pkg::REG_NORMAL_Y, 63'h10000);
		cfg_put(rdi_pkg::REG_NORMAL_Z, 63'h3_0000);
		cfg_put(rdi_pkg::REG_RADIUS_SQUARED, 63'h7fff_ffff_ffff_ffff);
		cfg_put(rdi_pkg::REG_MIN_DISTANCE, 63'h7fff_ffff_ffff_ffff);
		add_ray(32'h7fff_ffff, 0, 0, -65536, 0, 0, 31'h7fff_ffff, 1'b1);
		add_ray(32'h7fff_ffff, 32'h7fff_ffff, 0, -1, -1, 0, 31'h7fff_ffff, 1'b1);
		add_random(40);
		drain();

		// degenerate disk: zero normal, zero radius, no minimum, stray indexes
		cfg_put(rdi_pkg::REG_NORMAL_X, 63'h0);
		cfg_put(rdi_pkg::REG_NORMAL_Y, 63'h0);
		cfg_put(rdi_pkg::REG_NORMAL_Z, 63'h0);
		cfg_put(rdi_pkg::REG_RADIUS_SQUARED, 63'h0);
		cfg_put(rdi_pkg::REG_MIN_DISTANCE, 63'h0);
		cfg_put(4'd8, 63'h5555_5555_5555_5555);
		cfg_put(4'd15, 63'h7fff_ffff_ffff_ffff);
		add_random(30);
		drain();
		cfg_put(rdi_pkg::REG_NORMAL_Z, 63'h1_0000);
		cfg_put(rdi_pkg::REG_RADIUS_SQUARED, 63'h7fff_ffff_ffff_ffff);
		add_random(30);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			random_disk();
			if (ph == 9) quiet = 1'b1;
			add_random(110);
			drain();
		end

		$display("rays checked: %0d, hits among them: %0d", rays_sent, hits_seen);
		$display("covered reset, extreme, degenerate and 10 random disk settings");
		if (errors == 0 && hits_expected.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
